@@ rtl/ttli_pkg.sv @@
// Package for the time-table linear interpolator: sizes, input mode codes and
// the command and status structures between controller and datapath.
// No dependencies.
package ttli_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int FACES       = 16;
  localparam int ROW_W       = 6;
  localparam int FACE_W      = 4;
  localparam int CNT_W       = 7;
  localparam int TIME_W      = 32;
  localparam int VAL_W       = 32;
  localparam int FT_AW       = ROW_W + FACE_W;
  localparam int WGT_W       = 17;
  localparam int DIV_STEPS   = 17;
  localparam int DIV_CNT_W   = 5;

  localparam logic [1:0] MODE_WR_TIME = 2'd0;
  localparam logic [1:0] MODE_WR_FACE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [1:0] BT_SEL_ZERO = 2'd0;
  localparam logic [1:0] BT_SEL_CUR  = 2'd1;
  localparam logic [1:0] BT_SEL_NEXT = 2'd2;

  typedef struct packed {
    logic              wr_time;
    logic              wr_face;
    logic              ld_query;
    logic              ld_bt0;
    logic              ld_c_cur;
    logic              ld_tc0_chk;
    logic              walk_adv;
    logic              seg_hit;
    logic              seg_end;
    logic              row_first;
    logic              w_zero;
    logic              div_go;
    logic              ld_w;
    logic [1:0]        bt_sel;
    logic              issue;
    logic [FACE_W-1:0] face;
    logic              last;
  } ttli_cmd_t;

  typedef struct packed {
    logic t_le_q;
    logic seg_ok;
    logic c_end;
    logic seg_zero;
    logic div_done;
    logic pipe_busy;
  } ttli_sts_t;

endpackage

@@ rtl/ttli_div.sv @@
// Restoring divider for the interpolation weight, one quotient bit per cycle.
// Depends on ttli_pkg. The numerator never exceeds the denominator.
module ttli_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [ttli_pkg::TIME_W-1:0]      num,
  input  logic [ttli_pkg::TIME_W-1:0]      den,
  output logic                             done,
  output logic [ttli_pkg::WGT_W-1:0]       quo
);

  logic [ttli_pkg::TIME_W:0]         rem_r;
  logic [ttli_pkg::TIME_W-1:0]       den_r;
  logic [ttli_pkg::WGT_W-1:0]        q_r;
  logic [ttli_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic                              run_r;
  logic                              done_r;
  logic                              ge;
  logic [ttli_pkg::TIME_W:0]         diff;

  // The partial remainder stays below twice the divisor, so one compare and
  // subtract settles each bit.
  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= ttli_pkg::DIV_CNT_W'(ttli_pkg::DIV_STEPS - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= {diff[ttli_pkg::TIME_W-1:0], 1'b0};
      q_r   <= {q_r[ttli_pkg::WGT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/ttli_dp.sv @@
// Datapath of the interpolator: breakpoint and face memories, segment cursor,
// weight divider and the four-stage blend pipeline. Depends on ttli_pkg, ttli_div.
module ttli_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttli_pkg::ttli_cmd_t                 cmd,
  output ttli_pkg::ttli_sts_t                 sts,
  input  logic                                cfg_we,
  input  logic [ttli_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [ttli_pkg::ROW_W-1:0]          in_entry_index,
  input  logic [ttli_pkg::FACE_W-1:0]         in_face_index,
  input  logic [ttli_pkg::TIME_W-1:0]         in_time_value,
  input  logic signed [ttli_pkg::VAL_W-1:0]   in_face_value,
  output logic                                out_valid,
  output logic [ttli_pkg::FACE_W-1:0]         out_face,
  output logic signed [ttli_pkg::VAL_W-1:0]   out_value,
  output logic                                out_last_face
);

  localparam int PROD_W = ttli_pkg::WGT_W + 1 + ttli_pkg::VAL_W + 1;

  logic [ttli_pkg::TIME_W-1:0]        bt_mem [0:ttli_pkg::MAX_ENTRIES-1];
  logic signed [ttli_pkg::VAL_W-1:0]  ft_mem [0:ttli_pkg::MAX_ENTRIES*ttli_pkg::FACES-1];

  logic [ttli_pkg::CNT_W-1:0]   entries_used_r;
  logic [ttli_pkg::CNT_W-1:0]   n_r;
  logic [ttli_pkg::CNT_W-1:0]   n_nxt;
  logic [ttli_pkg::CNT_W-1:0]   n_m1;
  logic [ttli_pkg::TIME_W-1:0]  t_r;
  logic [ttli_pkg::ROW_W-1:0]   cur_r;
  logic [ttli_pkg::ROW_W-1:0]   cur_clamp;
  logic [ttli_pkg::ROW_W-1:0]   c_r;
  logic [ttli_pkg::ROW_W-1:0]   row0_r;
  logic [ttli_pkg::ROW_W-1:0]   row1_r;
  logic [ttli_pkg::TIME_W-1:0]  bt0_r;
  logic [ttli_pkg::TIME_W-1:0]  tc0_r;
  logic [ttli_pkg::TIME_W-1:0]  tc1_r;
  logic [ttli_pkg::TIME_W-1:0]  bt_q_r;
  logic [ttli_pkg::ROW_W-1:0]   bt_addr;
  logic [ttli_pkg::WGT_W-1:0]   w_r;
  logic [ttli_pkg::WGT_W-1:0]   div_quo;
  logic                         div_done;

  logic                              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [ttli_pkg::FACE_W-1:0]       s1_face_r, s2_face_r, s3_face_r, s4_face_r;
  logic                              s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic signed [ttli_pkg::VAL_W-1:0] f0_r, f1_r, f1_s2_r, f1_s3_r, val_r;
  logic signed [ttli_pkg::VAL_W:0]   diff_r;
  logic signed [PROD_W-1:0]          prod_r;

  // Register values outside 1..MAX_ENTRIES are pinned to the nearest bound.
  always_comb begin
    n_nxt = entries_used_r;
    if (entries_used_r == '0) begin
      n_nxt = ttli_pkg::CNT_W'(1);
    end else if (entries_used_r > ttli_pkg::CNT_W'(ttli_pkg::MAX_ENTRIES)) begin
      n_nxt = ttli_pkg::CNT_W'(ttli_pkg::MAX_ENTRIES);
    end
  end

  assign n_m1      = n_r - ttli_pkg::CNT_W'(1);
  assign cur_clamp = ({1'b0, cur_r} >= n_r) ? '0 : cur_r;

  always_comb begin
    case (cmd.bt_sel)
      ttli_pkg::BT_SEL_ZERO: bt_addr = '0;
      ttli_pkg::BT_SEL_CUR:  bt_addr = cur_clamp;
      ttli_pkg::BT_SEL_NEXT: bt_addr = c_r + ttli_pkg::ROW_W'(1);
      default:               bt_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_time) begin
      bt_mem[in_entry_index] <= in_time_value;
    end
    bt_q_r <= bt_mem[bt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_face) begin
      ft_mem[{in_entry_index, in_face_index}] <= in_face_value;
    end
    f0_r <= ft_mem[{row0_r, cmd.face}];
    f1_r <= ft_mem[{row1_r, cmd.face}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= ttli_pkg::CNT_W'(1);
      cur_r          <= '0;
    end else begin
      if (cfg_we) begin
        entries_used_r <= cfg_wdata;
      end
      if (cmd.wr_time || cmd.wr_face) begin
        cur_r <= '0;
      end else if (cmd.seg_hit || cmd.seg_end) begin
        cur_r <= c_r;
      end
    end
  end

  // Segment walk registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      t_r <= in_time_value;
      n_r <= n_nxt;
    end
    if (cmd.ld_bt0) begin
      bt0_r <= bt_q_r;
    end
    if (cmd.ld_c_cur) begin
      c_r <= cur_clamp;
    end else if (cmd.ld_tc0_chk && (t_r < bt_q_r)) begin
      c_r <= '0;
    end else if (cmd.walk_adv) begin
      c_r <= c_r + ttli_pkg::ROW_W'(1);
    end
    if (cmd.ld_tc0_chk) begin
      tc0_r <= (t_r < bt_q_r) ? bt0_r : bt_q_r;
    end else if (cmd.walk_adv) begin
      tc0_r <= bt_q_r;
    end
    if (cmd.seg_hit) begin
      tc1_r  <= bt_q_r;
      row0_r <= c_r;
      row1_r <= c_r + ttli_pkg::ROW_W'(1);
    end else if (cmd.seg_end) begin
      row0_r <= n_m1[ttli_pkg::ROW_W-1:0];
      row1_r <= n_m1[ttli_pkg::ROW_W-1:0];
    end else if (cmd.row_first) begin
      row0_r <= '0;
      row1_r <= '0;
    end
    if (cmd.w_zero) begin
      w_r <= '0;
    end else if (cmd.ld_w) begin
      w_r <= div_quo;
    end
  end

  ttli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   (tc1_r - t_r),
    .den   (tc1_r - tc0_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Blend as f1 + floor(w * (f0 - f1) / 2^16): the weighted sum, rounded down.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_face_r <= cmd.face;
    s1_last_r <= cmd.last;
    s2_face_r <= s1_face_r;
    s2_last_r <= s1_last_r;
    s3_face_r <= s2_face_r;
    s3_last_r <= s2_last_r;
    s4_face_r <= s3_face_r;
    s4_last_r <= s3_last_r;
    diff_r    <= {f0_r[ttli_pkg::VAL_W-1], f0_r} - {f1_r[ttli_pkg::VAL_W-1], f1_r};
    f1_s2_r   <= f1_r;
    prod_r    <= $signed({1'b0, w_r}) * diff_r;
    f1_s3_r   <= f1_s2_r;
    val_r     <= f1_s3_r + $signed(prod_r[ttli_pkg::VAL_W+15:16]);
  end

  assign sts.t_le_q    = t_r <= bt_q_r;
  assign sts.seg_ok    = (t_r >= tc0_r) && (t_r <= bt_q_r);
  assign sts.c_end     = ({1'b0, c_r} + ttli_pkg::CNT_W'(1)) >= n_r;
  assign sts.seg_zero  = tc1_r == tc0_r;
  assign sts.div_done  = div_done;
  assign sts.pipe_busy = s1_v_r || s2_v_r || s3_v_r;

  assign out_valid     = s4_v_r;
  assign out_face      = s4_face_r;
  assign out_value     = val_r;
  assign out_last_face = s4_last_r;

endmodule

@@ rtl/ttli_ctrl.sv @@
// Controller of the interpolator: sequences writes, the segment walk, the
// weight division and the face issue. Depends on ttli_pkg.
module ttli_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           mode,
  input  ttli_pkg::ttli_sts_t  sts,
  output ttli_pkg::ttli_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHK0   = 4'd1;
  localparam logic [3:0] ST_CURS   = 4'd2;
  localparam logic [3:0] ST_WISSUE = 4'd3;
  localparam logic [3:0] ST_WCMP   = 4'd4;
  localparam logic [3:0] ST_DIVGO  = 4'd5;
  localparam logic [3:0] ST_DIVW   = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [ttli_pkg::FACE_W-1:0] face_r, face_nxt;
  logic                        accept;
  logic                        face_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign face_last = face_r == ttli_pkg::FACE_W'(ttli_pkg::FACES - 1);

  always_comb begin
    state_nxt = state_r;
    face_nxt  = face_r;
    cmd       = '0;
    cmd.face  = face_r;
    case (state_r)
      ST_IDLE: begin
        face_nxt    = '0;
        cmd.bt_sel  = ttli_pkg::BT_SEL_ZERO;
        cmd.wr_time = accept && (mode == ttli_pkg::MODE_WR_TIME);
        cmd.wr_face = accept && (mode == ttli_pkg::MODE_WR_FACE);
        if (accept && (mode == ttli_pkg::MODE_QUERY)) begin
          cmd.ld_query = 1'b1;
          state_nxt    = ST_CHK0;
        end
      end
      ST_CHK0: begin
        cmd.bt_sel = ttli_pkg::BT_SEL_CUR;
        if (sts.t_le_q) begin
          cmd.row_first = 1'b1;
          cmd.w_zero    = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.ld_bt0   = 1'b1;
          cmd.ld_c_cur = 1'b1;
          state_nxt    = ST_CURS;
        end
      end
      ST_CURS: begin
        cmd.ld_tc0_chk = 1'b1;
        state_nxt      = ST_WISSUE;
      end
      ST_WISSUE: begin
        cmd.bt_sel = ttli_pkg::BT_SEL_NEXT;
        if (sts.c_end) begin
          cmd.seg_end = 1'b1;
          cmd.w_zero  = 1'b1;
          state_nxt   = ST_EMIT;
        end else begin
          state_nxt = ST_WCMP;
        end
      end
      ST_WCMP: begin
        if (sts.seg_ok) begin
          cmd.seg_hit = 1'b1;
          state_nxt   = ST_DIVGO;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = ST_WISSUE;
        end
      end
      ST_DIVGO: begin
        if (sts.seg_zero) begin
          cmd.w_zero = 1'b1;
          state_nxt  = ST_EMIT;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          cmd.ld_w  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.issue = 1'b1;
        cmd.last  = face_last;
        face_nxt  = face_r + ttli_pkg::FACE_W'(1);
        if (face_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      face_r  <= '0;
    end else begin
      state_r <= state_nxt;
      face_r  <= face_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

@@ rtl/time_table_linear_interpolator_core.sv @@
// Top level of the time-table linear interpolator: joins controller and
// datapath. Depends on ttli_pkg, ttli_ctrl and ttli_dp.
//
// Use: an item is taken on a clock edge where start is high and busy is low.
// in_mode selects a breakpoint time write, a face value write or a query.
// Writes complete in the accepting cycle, give no result and return the
// segment cursor to the first segment; the fourth mode code is ignored.
// A query yields sixteen result beats, one per face in ascending order, each
// shown for a single cycle with out_valid high; out_last_face marks the
// final beat. The receiver cannot stall, so beats leave at one per cycle.
// Path of a query: at or before the first breakpoint, or past the last, the
// row is read straight out with no division, in the latter case after the
// cursor has walked the remaining segments. An interpolating query walks
// from the segment cursor, one breakpoint memory read per segment stepped
// over, runs the weight divider unless the segment has zero length, and
// then issues the faces through the blend pipeline. Busy stays high through
// the final beat. The user must write the entries_used register through
// cfg_we and cfg_wdata only while the block is idle; the block itself does
// not enforce this.
// Reset clears the control state, the cursor and sets entries_used to one;
// the tables hold nothing defined until written.
module time_table_linear_interpolator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_mode,
  input  logic [ttli_pkg::ROW_W-1:0]          in_entry_index,
  input  logic [ttli_pkg::FACE_W-1:0]         in_face_index,
  input  logic [ttli_pkg::TIME_W-1:0]         in_time_value,
  input  logic signed [ttli_pkg::VAL_W-1:0]   in_face_value,
  input  logic                                cfg_we,
  input  logic [ttli_pkg::CNT_W-1:0]          cfg_wdata,
  output logic                                out_valid,
  output logic [ttli_pkg::FACE_W-1:0]         out_face,
  output logic signed [ttli_pkg::VAL_W-1:0]   out_value,
  output logic                                out_last_face
);

  ttli_pkg::ttli_cmd_t cmd;
  ttli_pkg::ttli_sts_t sts;

  // The controller alone decides what the datapath does each cycle.
  ttli_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memories, walk registers, divider and the blend pipeline.
  ttli_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_entry_index (in_entry_index),
    .in_face_index  (in_face_index),
    .in_time_value  (in_time_value),
    .in_face_value  (in_face_value),
    .out_valid      (out_valid),
    .out_face       (out_face),
    .out_value      (out_value),
    .out_last_face  (out_last_face)
  );

  // The only beat that may appear once busy has fallen is the final one.
  a_idle_beat_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last_face)
    else $error("result beat while idle is not the final face");

  // A query keeps the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == ttli_pkg::MODE_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // The last flag sits on the highest face.
  a_last_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_face |->
      (out_face == ttli_pkg::FACE_W'(ttli_pkg::FACES - 1)))
    else $error("last flag on wrong face");

  // Faces of one query come back to back, in ascending order.
  a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_face |=>
      out_valid && (out_face == $past(out_face) + ttli_pkg::FACE_W'(1)))
    else $error("face beats not contiguous");

endmodule
